@@ rtl/rc_pkg.sv @@
// rc_pkg: shared types, constants and digit mapping functions for the radix converter.
// No dependencies; used by rc_divider and radix_converter.
package rc_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int MAX_DIGITS     = 32;
  localparam int DIGIT_IDX_BITS = $clog2(MAX_DIGITS);
  localparam int COUNT_BITS     = DIGIT_IDX_BITS + 1;
  localparam int BASE_BITS      = 6;
  localparam int CHAR_BITS      = 8;
  localparam int CFG_INDEX_BITS = 2;

  localparam logic [BASE_BITS-1:0] BASE_MIN   = 6'd2;
  localparam logic [BASE_BITS-1:0] BASE_MAX   = 6'd36;
  localparam logic [BASE_BITS-1:0] BASE_RESET = 6'd10;
  localparam logic [BASE_BITS-1:0] NO_DIGIT   = 6'd63;

  localparam logic [CHAR_BITS-1:0] CHAR_ZERO    = 8'd48;  // '0'
  localparam logic [CHAR_BITS-1:0] CHAR_UPPER_A = 8'd65;  // 'A'
  localparam logic [CHAR_BITS-1:0] CHAR_LOWER_A = 8'd97;  // 'a'
  localparam logic [CHAR_BITS-1:0] CHAR_LOWER_END = 8'd123;
  localparam logic [CHAR_BITS-1:0] LETTER_COUNT = 8'd26;
  localparam logic [CHAR_BITS-1:0] DECIMAL_DIGITS = 8'd10;

  // configuration register indexes
  localparam logic [CFG_INDEX_BITS-1:0] REG_SOURCE_BASE = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DEST_BASE   = 2'd1;

  // error field codes
  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW = 2'd1;
  localparam logic [1:0] ERR_INVALID  = 2'd2;

  // sticky flag bit positions
  localparam int FLAG_OVF = 0;
  localparam int FLAG_INV = 1;

  typedef struct packed {
    logic [CHAR_BITS-1:0] char_code;
    logic                 last_char;
  } rc_in_t;

  typedef struct packed {
    logic [CHAR_BITS-1:0] digit_code;
    logic                 last_digit;
    logic [1:0]           error;
  } rc_out_t;

  function automatic logic [BASE_BITS-1:0] clamp_base(input logic [BASE_BITS-1:0] b);
    logic [BASE_BITS-1:0] r;
    r = b;
    if (b < BASE_MIN) r = BASE_MIN;
    else if (b > BASE_MAX) r = BASE_MAX;
    return r;
  endfunction

  // ASCII character to digit value; NO_DIGIT when it is not 0-9, a-z, A-Z
  function automatic logic [BASE_BITS-1:0] char_value(input logic [CHAR_BITS-1:0] c);
    logic [CHAR_BITS-1:0] v;
    v = {2'b00, NO_DIGIT};
    if (c >= CHAR_ZERO && c < CHAR_ZERO + DECIMAL_DIGITS) begin
      v = c - CHAR_ZERO;
    end else if (c >= CHAR_LOWER_A && c < CHAR_LOWER_END) begin
      v = DECIMAL_DIGITS + (c - CHAR_LOWER_A);
    end else if (c >= CHAR_UPPER_A && c < CHAR_UPPER_A + LETTER_COUNT) begin
      v = DECIMAL_DIGITS + (c - CHAR_UPPER_A);
    end
    return v[BASE_BITS-1:0];
  endfunction

  // digit value 0..35 to ASCII, 0-9 then uppercase letters
  function automatic logic [CHAR_BITS-1:0] digit_char(input logic [BASE_BITS-1:0] d);
    logic [CHAR_BITS-1:0] dv;
    dv = {2'b00, d};
    if (dv < DECIMAL_DIGITS) return CHAR_ZERO + dv;
    return CHAR_UPPER_A + (dv - DECIMAL_DIGITS);
  endfunction

endpackage

@@ rtl/rc_divider.sv @@
// rc_divider: bit-serial restoring divider, one quotient bit per cycle.
// Divides a VALUE_BITS value by a 6-bit base; depends on rc_pkg.
module rc_divider #(
  parameter int VALUE_BITS = rc_pkg::VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [VALUE_BITS-1:0]         dividend,
  input  logic [rc_pkg::BASE_BITS-1:0]  divisor,
  output logic                          done,
  output logic [VALUE_BITS-1:0]         quotient,
  output logic [rc_pkg::BASE_BITS-1:0]  remainder
);
  import rc_pkg::*;

  localparam int CNT_BITS = $clog2(VALUE_BITS);

  logic [CNT_BITS-1:0] cnt;
  logic                run;
  logic [BASE_BITS:0]  rem_sh;
  logic [BASE_BITS:0]  rem_diff;
  logic                ge;

  // shift in next dividend bit, trial subtract
  assign rem_sh   = {remainder, quotient[VALUE_BITS-1]};
  assign ge       = rem_sh >= {1'b0, divisor};
  assign rem_diff = rem_sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CNT_BITS'(VALUE_BITS - 1);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
    end else if (run) begin
      quotient  <= {quotient[VALUE_BITS-2:0], ge};
      remainder <= ge ? rem_diff[BASE_BITS-1:0] : rem_sh[BASE_BITS-1:0];
    end
  end

endmodule

@@ rtl/radix_converter.sv @@
// radix_converter: ASCII digits in one radix (2..36) to ASCII digits in another.
// Top level; depends on rc_pkg and rc_divider.
//
//  channel  | signals                                   | transfer when
//  ---------+-------------------------------------------+-------------------------------
//  input    | start, busy, item                         | start high and busy low
//  result   | result_valid, result                      | every cycle result_valid is high
//  config   | cfg_valid, cfg_ready, cfg_index, cfg_data | cfg_valid and cfg_ready high
//
// A character without last_char is folded into the accumulator in its transfer cycle;
// the block stays ready. A last character starts the conversion: the bit-serial divider
// produces the output digits one after another, then the digits stream out one per
// cycle. Reset (rst, synchronous) clears accumulator, flags and sequencer and sets
// both bases to 10. The receiver cannot stall: each result is up for one cycle.
module radix_converter #(
  parameter int VALUE_BITS = rc_pkg::VALUE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // input items
  input  logic                               start,
  output logic                               busy,
  input  rc_pkg::rc_in_t                     item,
  // results
  output logic                               result_valid,
  output rc_pkg::rc_out_t                    result,
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [rc_pkg::BASE_BITS-1:0]       cfg_data
);
  import rc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,  // folding characters
    S_DIV  = 3'b010,  // peeling off digits, least significant first
    S_EMIT = 3'b100   // reading digits back, most significant first
  } rc_state_t;

  rc_state_t state;

  // configuration, stored already clamped to 2..36
  logic [BASE_BITS-1:0] source_base;
  logic [BASE_BITS-1:0] dest_base;

  // conversion state
  logic [VALUE_BITS-1:0]     accumulator;
  logic [1:0]                error_flags;
  logic [COUNT_BITS-1:0]     digit_count;
  logic [DIGIT_IDX_BITS-1:0] rd_ptr;
  logic [BASE_BITS-1:0]      digit_store [MAX_DIGITS];

  // output stage
  logic                 rd_vld;
  logic                 rd_last;
  logic [BASE_BITS-1:0] rd_data;
  logic [1:0]           out_err;

  // divider hookup
  logic                  div_start;
  logic [VALUE_BITS-1:0] div_dividend;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_quot;
  logic [BASE_BITS-1:0]  div_rem;

  // Horner step on the incoming character
  logic                  accept;
  logic [BASE_BITS-1:0]  char_val;
  logic                  char_bad;
  logic [VALUE_BITS+BASE_BITS-1:0] horner_wide;
  logic                  horner_ovf;
  logic [VALUE_BITS-1:0] acc_next;
  logic [1:0]            flags_next;

  // per-digit decisions
  logic [COUNT_BITS-1:0] count_inc;
  logic                  quot_nz;
  logic                  more_digits;
  logic [1:0]            final_flags;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  assign char_val    = char_value(item.char_code);
  assign char_bad    = (char_val == NO_DIGIT) || (char_val >= source_base);
  assign horner_wide = {{BASE_BITS{1'b0}}, accumulator} * {{VALUE_BITS{1'b0}}, source_base}
                     + {{VALUE_BITS{1'b0}}, char_val};
  assign horner_ovf  = |horner_wide[VALUE_BITS+BASE_BITS-1:VALUE_BITS];

  always_comb begin
    acc_next   = accumulator;
    flags_next = error_flags;
    if (char_bad) begin
      flags_next[FLAG_INV] = 1'b1;
    end else begin
      acc_next = horner_wide[VALUE_BITS-1:0];
      if (horner_ovf) flags_next[FLAG_OVF] = 1'b1;
    end
  end

  // next digit: keep dividing while the quotient is nonzero and the store has room
  assign count_inc   = digit_count + 1'b1;
  assign quot_nz     = |div_quot;
  assign more_digits = quot_nz && (count_inc < COUNT_BITS'(MAX_DIGITS));

  always_comb begin
    final_flags = error_flags;
    if (quot_nz) final_flags[FLAG_OVF] = 1'b1;  // digits beyond the store are dropped
  end

  assign div_start    = (accept && item.last_char) ||
                        (state == S_DIV && div_done && more_digits);
  assign div_dividend = (state == S_IDLE) ? acc_next : div_quot;

  rc_divider #(
    .VALUE_BITS (VALUE_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (dest_base),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      source_base <= BASE_RESET;
      dest_base   <= BASE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SOURCE_BASE: source_base <= clamp_base(cfg_data);
        REG_DEST_BASE:   dest_base   <= clamp_base(cfg_data);
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      accumulator <= '0;
      error_flags <= '0;
      digit_count <= '0;
      rd_ptr      <= '0;
      rd_vld      <= 1'b0;
    end else begin
      rd_vld <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            accumulator <= acc_next;
            error_flags <= flags_next;
            if (item.last_char) begin
              digit_count <= '0;
              state       <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            digit_count <= count_inc;
            if (!more_digits) begin
              // conversion finished: clear for the next number
              accumulator <= '0;
              error_flags <= '0;
              rd_ptr      <= digit_count[DIGIT_IDX_BITS-1:0];
              state       <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          rd_vld <= 1'b1;
          rd_ptr <= rd_ptr - 1'b1;
          if (rd_ptr == '0) begin
            digit_count <= '0;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // error code and read-side payload
  always_ff @(posedge clk) begin
    if (state == S_DIV && div_done && !more_digits) begin
      if (final_flags[FLAG_INV])      out_err <= ERR_INVALID;
      else if (final_flags[FLAG_OVF]) out_err <= ERR_OVERFLOW;
      else                            out_err <= ERR_OK;
    end
    if (state == S_EMIT) begin
      rd_last <= (rd_ptr == '0);
    end
  end

  // digit store: written per remainder, read back in reverse
  always_ff @(posedge clk) begin
    if (state == S_DIV && div_done) begin
      digit_store[digit_count[DIGIT_IDX_BITS-1:0]] <= div_rem;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= digit_store[rd_ptr];
  end

  assign result_valid      = rd_vld;
  assign result.digit_code = digit_char(rd_data);
  assign result.last_digit = rd_last;
  assign result.error      = out_err;

  // the final digit of a number is never followed directly by another digit
  a_last_ends_burst: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.last_digit |=> !result_valid)
    else $error("digit emitted right after final digit");

  // a final character always launches a conversion
  a_last_starts_conv: assert property (@(posedge clk) disable iff (rst)
    accept && item.last_char |=> busy && (state == S_DIV))
    else $error("final character did not start conversion");

  // the divider only finishes while the sequencer waits for it
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_DIV))
    else $error("divider done outside of divide phase");

  // digit count never passes the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    digit_count <= COUNT_BITS'(MAX_DIGITS))
    else $error("digit count beyond store depth");

endmodule
